// File: sv/qprd_pkg.sv
// Shared types, register indexes and constants for the quadrature position and rate decoder.
package qprd_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_MS = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_Q16 = 1'b1;

	// Configuration reset values: a one second window and 1/3.333 degree per count.
	localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
	localparam logic [15:0] SCALE_Q16_RESET = 16'd19663;

	// Limits of the 24-bit result fields.
	localparam logic [23:0] OUT_UMAX = 24'hFFFFFF;
	localparam logic [23:0] OUT_SMAX = 24'h7FFFFF;
	localparam logic [23:0] OUT_SMIN = 24'h800000;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// Distance between two phases along the counting-up cycle.
	localparam logic [1:0] MOVE_UP = 2'd1;
	localparam logic [1:0] MOVE_DOWN = 2'd3;

	typedef struct packed {
		logic [1:0] phase;
		logic       tick;
		logic       clear_steps;
		logic       clear_error;
	} in_word_t;

	typedef struct packed {
		logic [7:0]         step_count;
		logic signed [23:0] position;
		logic signed [23:0] angle_deg;
		logic [23:0]        rate_q8;
		logic               dir_forward;
		logic               dir_backward;
		logic               error_flag;
		logic               phase_changed;
	} out_word_t;

	// Everything of a decoded word except position and angle.
	typedef struct packed {
		logic [7:0]  step_count;
		logic [23:0] rate_q8;
		logic        dir_forward;
		logic        dir_backward;
		logic        error_flag;
		logic        phase_changed;
	} snap_t;

	// Place of each phase along the counting-up cycle 0, 2, 3, 1.
	function automatic logic [1:0] cycle_pos(input logic [1:0] ph);
		logic [1:0] p;
		case (ph)
			2'd0: p = 2'd0;
			2'd1: p = 2'd3;
			2'd2: p = 2'd1;
			2'd3: p = 2'd2;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// File: sv/qprd_decode.sv
// Phase decoder with step, position, transition and rate state, and the first result stage.
module qprd_decode #(
	parameter int unsigned POSITION_BITS = 24,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  qprd_pkg::in_word_t       sample,
	input  logic [15:0]              window_ms,
	input  logic [15:0]              scale_q16,
	output qprd_pkg::snap_t          snap_s1,
	output logic [POSITION_BITS-1:0] pos_s1
);

	localparam int unsigned RW = (COUNT_BITS + 8 > 24) ? COUNT_BITS + 8 : 24;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
	localparam logic [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] TRANS_MAX = {COUNT_BITS{1'b1}};

	logic [1:0]               last_phase_q;
	logic [7:0]               steps_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0]    trans_q;
	logic [15:0]              elapsed_q;
	logic [23:0]              rate_q;
	logic                     error_q;
	logic [1:0]               dir_q;

	logic [15:0]              win;
	logic [15:0]              elapsed_inc;
	logic                     win_end;
	logic [COUNT_BITS+15:0]   rate_prod;
	logic [RW-1:0]            rate_ext;
	logic [23:0]              rate_sat;
	logic [COUNT_BITS-1:0]    trans_base;
	logic [7:0]               steps_base;
	logic                     error_base;
	logic                     changed;
	logic [1:0]               ring_step;
	logic                     up;
	logic                     down;

	logic [1:0]               last_phase_d;
	logic [7:0]               steps_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic [COUNT_BITS-1:0]    trans_d;
	logic [15:0]              elapsed_d;
	logic [23:0]              rate_d;
	logic                     error_d;
	logic [1:0]               dir_d;

	assign rate_prod = (COUNT_BITS+16)'(trans_q) * (COUNT_BITS+16)'(scale_q16);
	assign rate_ext = RW'(rate_prod[COUNT_BITS+15:8]);

	always_comb begin
		// Window bookkeeping comes first; a window of zero behaves as one.
		win = (window_ms == 16'd0) ? 16'd1 : window_ms;
		elapsed_inc = (elapsed_q != qprd_pkg::ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
		win_end = sample.tick && (elapsed_inc >= win);
		rate_sat = (rate_ext > RW'(qprd_pkg::OUT_UMAX)) ? qprd_pkg::OUT_UMAX : rate_ext[23:0];
		elapsed_d = sample.tick ? (win_end ? 16'd0 : elapsed_inc) : elapsed_q;
		rate_d = win_end ? rate_sat : rate_q;
		trans_base = win_end ? '0 : trans_q;

		// Clears act before this word is decoded.
		steps_base = sample.clear_steps ? 8'd0 : steps_q;
		error_base = sample.clear_error ? 1'b0 : error_q;

		changed = (sample.phase != last_phase_q);
		ring_step = qprd_pkg::cycle_pos(sample.phase) - qprd_pkg::cycle_pos(last_phase_q);
		up = changed && (ring_step == qprd_pkg::MOVE_UP);
		down = changed && (ring_step == qprd_pkg::MOVE_DOWN);

		steps_d = steps_base;
		pos_d = pos_q;
		trans_d = trans_base;
		dir_d = dir_q;
		last_phase_d = last_phase_q;
		error_d = error_base;
		if (up) begin
			steps_d = steps_base + 8'd1;
			if (pos_q != POS_MAX) pos_d = pos_q + POSITION_BITS'(1);
			dir_d = 2'b01;
		end else if (down) begin
			steps_d = steps_base - 8'd1;
			if (pos_q != POS_MIN) pos_d = pos_q - POSITION_BITS'(1);
			dir_d = 2'b10;
		end else if (changed) begin
			// Both lines moved at once: flag it and keep the old phase.
			error_d = 1'b1;
		end
		if (up || down) begin
			last_phase_d = sample.phase;
			if (trans_base != TRANS_MAX) trans_d = trans_base + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'd0;
			steps_q <= 8'd0;
			pos_q <= '0;
			trans_q <= '0;
			elapsed_q <= 16'd0;
			rate_q <= 24'd0;
			error_q <= 1'b0;
			dir_q <= 2'b00;
		end else if (fire) begin
			last_phase_q <= last_phase_d;
			steps_q <= steps_d;
			pos_q <= pos_d;
			trans_q <= trans_d;
			elapsed_q <= elapsed_d;
			rate_q <= rate_d;
			error_q <= error_d;
			dir_q <= dir_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			snap_s1.step_count <= steps_d;
			snap_s1.rate_q8 <= rate_d;
			snap_s1.dir_forward <= dir_d[0];
			snap_s1.dir_backward <= dir_d[1];
			snap_s1.error_flag <= error_d;
			snap_s1.phase_changed <= changed;
			pos_s1 <= pos_d;
		end
	end

endmodule

// File: sv/qprd_angle.sv
// Angle scaling, 24-bit saturation and the result register.
module qprd_angle #(
	parameter int unsigned POSITION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     load,
	input  qprd_pkg::snap_t          snap_s1,
	input  logic [POSITION_BITS-1:0] pos_s1,
	input  logic [15:0]              scale_q16,
	output qprd_pkg::out_word_t      result_q
);

	localparam int unsigned MW = (POSITION_BITS > 24) ? POSITION_BITS : 24;

	logic                     neg;
	logic [POSITION_BITS-1:0] mag;
	logic [POSITION_BITS+15:0] prod;
	logic [POSITION_BITS-1:0] angle_mag;
	logic [23:0]              pos_out;
	logic [23:0]              angle_out;

	// Clamp a sign and magnitude pair into a signed 24-bit field.
	function automatic logic [23:0] sat24(input logic n, input logic [MW-1:0] m);
		logic [MW-1:0] t;
		t = ~m + MW'(1);
		if (n) begin
			return (m > MW'(qprd_pkg::OUT_SMIN)) ? qprd_pkg::OUT_SMIN : t[23:0];
		end else begin
			return (m > MW'(qprd_pkg::OUT_SMAX)) ? qprd_pkg::OUT_SMAX : m[23:0];
		end
	endfunction

	always_comb begin
		neg = pos_s1[POSITION_BITS-1];
		mag = neg ? (~pos_s1 + POSITION_BITS'(1)) : pos_s1;
		prod = (POSITION_BITS+16)'(mag) * (POSITION_BITS+16)'(scale_q16);
		// The product is taken on the magnitude, so the angle truncates toward zero.
		angle_mag = prod[POSITION_BITS+15:16];
		pos_out = sat24(neg, MW'(mag));
		angle_out = sat24(neg, MW'(angle_mag));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.step_count <= snap_s1.step_count;
			result_q.position <= pos_out;
			result_q.angle_deg <= angle_out;
			result_q.rate_q8 <= snap_s1.rate_q8;
			result_q.dir_forward <= snap_s1.dir_forward;
			result_q.dir_backward <= snap_s1.dir_backward;
			result_q.error_flag <= snap_s1.error_flag;
			result_q.phase_changed <= snap_s1.phase_changed;
		end
	end

endmodule

// File: sv/quadrature_position_rate_decoder.sv
// Top level of the x4 quadrature decoder with position, angle and rate outputs.
// An accepted word goes from stage one into the result register once that is empty or draining.
// Throughput: one sample word per cycle unless stalled; the decoder updates in the accept cycle.
// The two stages advance independently, so a stalled result still leaves room for one more word.
// Reset: arst_n clears all decoder state and both valid flags at once and loads the
// configuration defaults (a 1000 tick window and a scale of 19663 in Q0.16); no clearing pass.
module quadrature_position_rate_decoder #(
	parameter int unsigned POSITION_BITS = 24,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	// Sample channel: one word per encoder sample.
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  qprd_pkg::in_word_t                     sample,

	// Result channel: one word per sample.
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output qprd_pkg::out_word_t                    result,

	// Configuration write channel.
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [qprd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [15:0]                            cfg_data
);

	logic [15:0]              window_ms_q;
	logic [15:0]              scale_q16_q;
	logic                     s1_valid_q;
	logic                     result_valid_q;
	logic                     s1_adv;
	logic                     fire;
	qprd_pkg::snap_t          snap_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	// Configuration is always writable; writes are only expected while the decoder is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= qprd_pkg::WINDOW_MS_RESET;
			scale_q16_q <= qprd_pkg::SCALE_Q16_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				qprd_pkg::CFG_WINDOW_MS: window_ms_q <= cfg_data;
				qprd_pkg::CFG_SCALE_Q16: scale_q16_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage one moves into the result register whenever that register is empty or
	// being drained. A new sample is taken whenever stage one is empty or moving on.
	assign s1_adv = s1_valid_q && (!result_valid_q || !result_stall);
	assign sample_stall = s1_valid_q && !s1_adv;
	assign fire = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire) s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

	// Decoder: phase decode, counters, window and rate, all updated as the word is accepted.
	qprd_decode #(
		.POSITION_BITS(POSITION_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.sample(sample),
		.window_ms(window_ms_q),
		.scale_q16(scale_q16_q),
		.snap_s1(snap_s1),
		.pos_s1(pos_s1)
	);

	// Angle multiply and output saturation into the result register.
	qprd_angle #(
		.POSITION_BITS(POSITION_BITS)
	) u_angle (
		.clk(clk),
		.load(s1_adv),
		.snap_s1(snap_s1),
		.pos_s1(pos_s1),
		.scale_q16(scale_q16_q),
		.result_q(result)
	);

`ifndef SYNTHESIS
	// The decoder never reports both directions at once.
	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.dir_forward && result.dir_backward))
		else $error("both direction flags set");

	// Input is only held off when both stages are full and the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (s1_valid_q && result_valid_q && result_stall))
		else $error("sample stalled with room in the pipeline");

	// An accepted word always lands in stage one.
	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> s1_valid_q)
		else $error("accepted word lost before stage one");

	// A word leaving stage one always lands in the result register.
	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> result_valid_q)
		else $error("stage one word lost before the result register");
`endif

endmodule
